@@ rtl/twcp_pkg.sv @@
// Shared constants, codes and pipeline types for the wall column texturing block
package twcp_pkg;

	// Screen and texture geometry (texture size must be a power of two)
	localparam int SCREEN_HEIGHT = 480;
	localparam int TEXTURE_SIZE  = 64;
	localparam int TEXTURE_COUNT = 8;

	localparam int TEX_BITS    = $clog2(TEXTURE_SIZE);
	localparam int TEXELS      = TEXTURE_SIZE * TEXTURE_SIZE;
	localparam int STORE_DEPTH = TEXTURE_COUNT * TEXELS;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);

	// Field widths
	localparam int COLOR_W    = 24;
	localparam int CHAN_W     = 8;
	localparam int STRIDE_W   = 14;
	localparam int PIX_ADDR_W = 24;
	localparam int HEIGHT_W   = 16;
	localparam int ROW_W      = 10;
	localparam int COL_W      = 10;

	// Divider: remainder and signed numerator widths, one quotient bit a stage
	localparam int REM_W     = HEIGHT_W + 1;
	localparam int NUM_W     = REM_W + 1;
	localparam int DIV_STEPS = TEX_BITS;

	// Queue between front and back end
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	// Edges from the accepting edge to the edge that samples the strobe
	localparam int PIPE_LATENCY = DIV_STEPS + 3;

	localparam logic [STRIDE_W-1:0] STRIDE_RESET = STRIDE_W'(2560);
	localparam logic [COLOR_W-1:0]  HALF_MASK    = COLOR_W'(8355711);

	typedef enum logic {
		FUNC_LOAD = 1'b0,
		FUNC_DRAW = 1'b1
	} func_t;

	// One queued item, already classified by the front end
	typedef struct packed {
		logic                  is_load;
		logic                  black;
		logic                  shade;
		logic                  trow_zero;
		logic                  trow_sat;
		logic [ADDR_W-1:0]     base;
		logic [COLOR_W-1:0]    texel;
		logic [REM_W-1:0]      num;
		logic [HEIGHT_W-1:0]   height;
		logic [ROW_W-1:0]      row;
		logic [COL_W-1:0]      column;
	} work_t;

	// One divider stage of the back end
	typedef struct packed {
		logic                  valid;
		logic                  is_load;
		logic                  black;
		logic                  shade;
		logic                  trow_zero;
		logic                  trow_sat;
		logic [ADDR_W-1:0]     base;
		logic [COLOR_W-1:0]    texel;
		logic [REM_W-1:0]      rem;
		logic [HEIGHT_W-1:0]   height;
		logic [TEX_BITS-1:0]   quo;
		logic [PIX_ADDR_W-1:0] pix_addr;
	} div_t;

endpackage

@@ rtl/twcp_ram.sv @@
// Generic single-write, single-read RAM with registered read data
module twcp_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 32768
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write one word, read one word
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/twcp_front.sv @@
// Front end: accept items, drop no-op loads and off-span pixels, prepare divider operands
module twcp_front
	import twcp_pkg::*;
(
	input  logic                start,
	input  logic                busy,
	input  logic                func,
	input  logic [2:0]          texture_select,
	input  logic [11:0]         texel_index,
	input  logic [COLOR_W-1:0]  texel_value,
	input  logic [COL_W-1:0]    column,
	input  logic [ROW_W-1:0]    row,
	input  logic [9:0]          span_start,
	input  logic [10:0]         span_end,
	input  logic [HEIGHT_W-1:0] wall_height,
	input  logic [5:0]          texture_column,
	input  logic                shade_side,
	output logic                push,
	output work_t               entry
);

	logic                    is_load;
	logic                    sel_ok;
	logic                    index_ok;
	logic                    in_span;
	logic                    keep;
	logic signed [NUM_W-1:0] num;
	logic [REM_W-1:0]        twice_height;
	logic [TEX_BITS-1:0]     tcol_sat;
	logic [ADDR_W-1:0]       load_addr;
	logic [ADDR_W-1:0]       draw_base;

	// Classify the item
	always_comb begin
		is_load  = (func == FUNC_LOAD);
		sel_ok   = 32'(texture_select) < TEXTURE_COUNT;
		index_ok = 32'(texel_index) < TEXELS;
		in_span  = (row >= span_start) && ({1'b0, row} < span_end);
		keep     = is_load ? (sel_ok && index_ok) : in_span;
		push     = start && !busy && keep;
	end

	// Texture row numerator: d / 128 = 2*row - screen height + wall height
	always_comb begin
		num = $signed(NUM_W'({row, 1'b0}) - NUM_W'(SCREEN_HEIGHT) + NUM_W'(wall_height));
		twice_height = {wall_height, 1'b0};
	end

	// Store addresses: full texel address for loads, texture plus column for draws
	always_comb begin
		tcol_sat  = (32'(texture_column) >= TEXTURE_SIZE) ? TEX_BITS'(TEXTURE_SIZE - 1)
		                                                  : TEX_BITS'(texture_column);
		load_addr = ADDR_W'(32'(texture_select) * TEXELS + 32'(texel_index));
		draw_base = ADDR_W'(32'(texture_select) * TEXELS + 32'(tcol_sat));
	end

	// Pack the queue entry
	always_comb begin
		entry.is_load   = is_load;
		entry.black     = !sel_ok;
		entry.shade     = shade_side;
		entry.trow_zero = (wall_height == '0) || (num <= 0);
		entry.trow_sat  = !num[NUM_W-1] && (REM_W'(num) >= twice_height);
		entry.base      = is_load ? load_addr : draw_base;
		entry.texel     = texel_value;
		entry.num       = REM_W'(num);
		entry.height    = wall_height;
		entry.row       = row;
		entry.column    = column;
	end

endmodule

@@ rtl/twcp_queue.sv @@
// Short FIFO between front and back end
module twcp_queue
	import twcp_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  work_t push_entry,
	input  logic  pop,
	output logic  full,
	output logic  head_valid,
	output work_t head
);

	work_t                  slots_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [QUEUE_CNT_W-1:0] count_q;

	function automatic logic [QUEUE_PTR_W-1:0] next_ptr(input logic [QUEUE_PTR_W-1:0] ptr);
		return (ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + 1'b1;
	endfunction

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			count_q <= count_q + QUEUE_CNT_W'(push) - QUEUE_CNT_W'(pop);
		end
	end

	// Hold entries
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

	assign full       = (count_q == QUEUE_CNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = slots_q[rd_ptr_q];

endmodule

@@ rtl/twcp_back.sv @@
// Back end: pipelined texture row divider, texture store access, shading and output
module twcp_back
	import twcp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [STRIDE_W-1:0]   line_stride,
	input  logic                  head_valid,
	input  work_t                 head,
	output logic                  pop,
	output logic                  strobe,
	output logic [PIX_ADDR_W-1:0] pixel_address,
	output logic [CHAN_W-1:0]     red,
	output logic [CHAN_W-1:0]     green,
	output logic [CHAN_W-1:0]     blue
);

	div_t                  seed;
	div_t                  div_s [DIV_STEPS];
	div_t                  last;
	logic [TEX_BITS-1:0]   trow;
	logic [ADDR_W-1:0]     ram_addr;
	logic                  ram_we;
	logic [COLOR_W-1:0]    texel_rd;
	logic                  fetch_valid_s;
	logic                  fetch_black_s;
	logic                  fetch_shade_s;
	logic [PIX_ADDR_W-1:0] fetch_addr_s;
	logic [COLOR_W-1:0]    color;
	logic                  strobe_q;
	logic [PIX_ADDR_W-1:0] addr_q;
	logic [COLOR_W-1:0]    color_q;

	// Drain the queue every cycle: nothing downstream stalls
	assign pop = head_valid;

	// Load the first divider stage and form the framebuffer address
	always_comb begin
		seed           = '0;
		seed.valid     = head_valid;
		seed.is_load   = head.is_load;
		seed.black     = head.black;
		seed.shade     = head.shade;
		seed.trow_zero = head.trow_zero;
		seed.trow_sat  = head.trow_sat;
		seed.base      = head.base;
		seed.texel     = head.texel;
		seed.rem       = head.num;
		seed.height    = head.height;
		seed.quo       = '0;
		seed.pix_addr  = PIX_ADDR_W'(head.row) * PIX_ADDR_W'(line_stride)
		               + PIX_ADDR_W'({head.column, 2'b00});
	end

	// Restoring divider, one quotient bit per stage: integer bit first, then fraction
	genvar k;
	generate
		for (k = 0; k < DIV_STEPS; k++) begin : g_div
			div_t             src;
			div_t             nxt;
			logic [REM_W-1:0] trial;
			logic             ge;

			if (k == 0) begin : g_first
				assign src   = seed;
				assign trial = seed.rem;
			end else begin : g_next
				assign src   = div_s[k-1];
				assign trial = {div_s[k-1].rem[REM_W-2:0], 1'b0};
			end

			always_comb begin
				ge      = trial >= {1'b0, src.height};
				nxt     = src;
				nxt.rem = ge ? (trial - {1'b0, src.height}) : trial;
				nxt.quo = {src.quo[TEX_BITS-2:0], ge};
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					div_s[k].valid <= 1'b0;
				end else begin
					div_s[k] <= nxt;
				end
			end
		end
	endgenerate

	// Clamp the texture row and address the store
	always_comb begin
		last = div_s[DIV_STEPS-1];
		if (last.trow_zero) begin
			trow = '0;
		end else if (last.trow_sat) begin
			trow = TEX_BITS'(TEXTURE_SIZE - 1);
		end else begin
			trow = last.quo;
		end
		ram_addr = last.is_load ? last.base
		                        : last.base + ADDR_W'(32'(trow) * TEXTURE_SIZE);
		ram_we   = last.valid && last.is_load;
	end

	twcp_ram #(
		.WIDTH(COLOR_W),
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_addr),
		.wdata(last.texel),
		.raddr(ram_addr),
		.rdata(texel_rd)
	);

	// Carry draw side info alongside the store read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fetch_valid_s <= 1'b0;
		end else begin
			fetch_valid_s <= last.valid && !last.is_load;
		end
	end

	always_ff @(posedge clk) begin
		fetch_black_s <= last.black;
		fetch_shade_s <= last.shade;
		fetch_addr_s  <= last.pix_addr;
	end

	// Black out bad textures, halve each channel on y-side walls
	always_comb begin
		color = fetch_black_s ? '0 : texel_rd;
		if (fetch_shade_s) begin
			color = (color >> 1) & HALF_MASK;
		end
	end

	// Register the result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= fetch_valid_s;
		end
	end

	always_ff @(posedge clk) begin
		addr_q  <= fetch_addr_s;
		color_q <= color;
	end

	assign strobe        = strobe_q;
	assign pixel_address = addr_q;
	assign red           = color_q[CHAN_W-1:0];
	assign green         = color_q[2*CHAN_W-1:CHAN_W];
	assign blue          = color_q[3*CHAN_W-1:2*CHAN_W];

endmodule

@@ rtl/textured_wall_column_pixel.sv @@
// Top level of the raycaster wall column texturing block
// Usage:
//   Items enter on start when busy is low. A load item (func 0) writes one texel into
//   the texture store; a draw item (func 1) produces at most one pixel result.
//   Loads and draws run through the same in-order pipeline, so a draw always sees
//   every load accepted before it.
//   Results leave as one-cycle beats marked by strobe, carrying pixel_address and the
//   red, green and blue bytes. The receiver cannot hold them off.
//   line_stride is written over cfg_valid/cfg_ready/cfg_data; cfg_ready is always high.
// Timing:
//   One item per clock. A draw accepted into the queue passes one divider stage per
//   texture row bit, then the store read and then the output register, which raises
//   its strobe. The store's write and read ports share one address, used in order by
//   loads and draws. busy rises only if the two-beat queue fills, which the
//   non-stalling back end prevents.
// Reset:
//   Clears all valid flags and sets line_stride to 2560. The texture store is not
//   cleared: texels read before they were loaded hold no defined value.
module textured_wall_column_pixel
	import twcp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic                  func,
	input  logic [2:0]            texture_select,
	input  logic [11:0]           texel_index,
	input  logic [COLOR_W-1:0]    texel_value,
	input  logic [COL_W-1:0]      column,
	input  logic [ROW_W-1:0]      row,
	input  logic [9:0]            span_start,
	input  logic [10:0]           span_end,
	input  logic [HEIGHT_W-1:0]   wall_height,
	input  logic [5:0]            texture_column,
	input  logic                  shade_side,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [STRIDE_W-1:0]   cfg_data,
	output logic                  strobe,
	output logic [PIX_ADDR_W-1:0] pixel_address,
	output logic [CHAN_W-1:0]     red,
	output logic [CHAN_W-1:0]     green,
	output logic [CHAN_W-1:0]     blue
);

	logic [STRIDE_W-1:0] stride_q;
	logic                push;
	work_t               entry;
	logic                pop;
	logic                full;
	logic                head_valid;
	work_t               head;

	// Take configuration beats at any time
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stride_q <= STRIDE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			stride_q <= cfg_data;
		end
	end

	assign busy = full;

	twcp_front u_front (
		.start         (start),
		.busy          (busy),
		.func          (func),
		.texture_select(texture_select),
		.texel_index   (texel_index),
		.texel_value   (texel_value),
		.column        (column),
		.row           (row),
		.span_start    (span_start),
		.span_end      (span_end),
		.wall_height   (wall_height),
		.texture_column(texture_column),
		.shade_side    (shade_side),
		.push          (push),
		.entry         (entry)
	);

	twcp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(entry),
		.pop       (pop),
		.full      (full),
		.head_valid(head_valid),
		.head      (head)
	);

	twcp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.line_stride  (stride_q),
		.head_valid   (head_valid),
		.head         (head),
		.pop          (pop),
		.strobe       (strobe),
		.pixel_address(pixel_address),
		.red          (red),
		.green        (green),
		.blue         (blue)
	);

	// The back end never stalls, so the queue never fills
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("queue filled up");

	// Every result comes from an earlier accepted draw inside its span
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(start && !busy && (func == FUNC_DRAW) && (row >= span_start)
		                 && ({1'b0, row} < span_end), PIPE_LATENCY))
		else $error("result without a matching draw");

	// The address travels with its own pixel
	a_result_address: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> pixel_address == PIX_ADDR_W'($past(row, PIPE_LATENCY)) * PIX_ADDR_W'(stride_q)
		           + PIX_ADDR_W'({$past(column, PIPE_LATENCY), 2'b00}))
		else $error("pixel address out of step");

endmodule
